>>> sv/fpm_pkg.sv
// Shared types and constants for the Fenwick prefix-max table.
`timescale 1ns / 1ps

package fpm_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_VALUE_WIDTH = 32;
  localparam int USED_SIZE_RESET = 1024;

  localparam logic CMD_RAISE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
    logic clear_step;
    logic load_out;
  } fpm_ctl_t;

  typedef struct packed {
    logic walk_more;
    logic rd_pend;
    logic is_query;
    logic clear_last;
  } fpm_sts_t;

endpackage

>>> sv/fpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/fpm_dp.sv
// Datapath: size register, tree walk registers, node memory and result register.
`timescale 1ns / 1ps

module fpm_dp import fpm_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  localparam int IW = $clog2(TABLE_DEPTH),
  localparam int SW = $clog2(TABLE_DEPTH + 1),
  localparam int NW = IW + 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [SW-1:0]          cfg_data,
  input  logic                   cmd,
  input  logic [IW-1:0]          index,
  input  logic [VALUE_WIDTH-1:0] value,
  input  fpm_ctl_t               ctl,
  output fpm_sts_t               sts,
  output logic [VALUE_WIDTH-1:0] prefix_max
);

  localparam logic [SW-1:0] DEPTH_S = SW'(TABLE_DEPTH);
  localparam logic [SW-1:0] SIZE_RST =
    SW'((TABLE_DEPTH < USED_SIZE_RESET) ? TABLE_DEPTH : USED_SIZE_RESET);
  localparam logic [IW-1:0] LAST_ADDR = IW'(TABLE_DEPTH - 1);

  logic [SW-1:0]          used_size;
  logic [SW-1:0]          n_eff;
  logic [NW-1:0]          n_ext;
  logic [NW-1:0]          idx_ext;
  logic [NW-1:0]          pos;
  logic [NW-1:0]          n_r;
  logic [NW-1:0]          node;
  logic [NW-1:0]          lowbit;
  logic                   is_query;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [VALUE_WIDTH-1:0] best;
  logic [VALUE_WIDTH-1:0] best_next;
  logic                   rd_pend;
  logic [IW-1:0]          rd_addr;
  logic [IW-1:0]          clr_addr;
  logic                   walk_more;
  logic                   data_hit;
  logic                   ram_we;
  logic [IW-1:0]          ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic [IW-1:0]          ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  // Size zero acts as one, oversize acts as the full table.
  always_comb begin
    if (used_size == '0) begin
      n_eff = SW'(1);
    end else if (used_size > DEPTH_S) begin
      n_eff = DEPTH_S;
    end else begin
      n_eff = used_size;
    end
    n_ext   = NW'(n_eff);
    idx_ext = NW'(index);
    pos     = (idx_ext >= n_ext) ? (n_ext - NW'(1)) : idx_ext;
  end

  assign lowbit    = node & (~node + NW'(1));
  assign walk_more = is_query ? (node != '0) : (node <= n_r);
  assign data_hit  = ctl.step && rd_pend;
  assign ram_raddr = IW'(node - NW'(1));

  always_comb begin
    best_next = best;
    if (data_hit && is_query && (ram_rdata > best)) begin
      best_next = ram_rdata;
    end
  end

  // Clearing pass owns the write port; otherwise write back a raised node.
  always_comb begin
    if (ctl.clear_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = data_hit && !is_query && (ram_rdata < val_r);
      ram_waddr = rd_addr;
      ram_wdata = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_size <= SIZE_RST;
      rd_pend   <= 1'b0;
      clr_addr  <= '0;
    end else begin
      if (cfg_we) begin
        used_size <= cfg_data;
      end
      rd_pend <= ctl.step && walk_more;
      if (ctl.clear_step) begin
        clr_addr <= clr_addr + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      node     <= pos + NW'(1);
      n_r      <= n_ext;
      is_query <= (cmd == CMD_QUERY);
      val_r    <= value;
      best     <= '0;
    end else begin
      best <= best_next;
      if (ctl.step && walk_more) begin
        rd_addr <= ram_raddr;
        // Query walks down to the root, raise walks up past the size.
        node    <= is_query ? (node - lowbit) : (node + lowbit);
      end
    end
    if (ctl.load_out) begin
      prefix_max <= best_next;
    end
  end

  fpm_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign sts.walk_more  = walk_more;
  assign sts.rd_pend    = rd_pend;
  assign sts.is_query   = is_query;
  assign sts.clear_last = (clr_addr == LAST_ADDR);

  // A node write outside the clearing pass comes only from a raise with data back.
  a_write_src: assert property (@(posedge clk) disable iff (rst)
    (ram_we && !ctl.clear_step) |-> (rd_pend && !is_query))
    else $error("node write without a pending raise read");

  // Read data is consumed only in the cycle after a walk step issued it.
  a_pend_origin: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> $past(ctl.step))
    else $error("pending read without a prior walk step");

  // Raise writes never lower a node.
  a_raise_up: assert property (@(posedge clk) disable iff (rst)
    (ram_we && !ctl.clear_step) |-> (ram_wdata > ram_rdata))
    else $error("raise write would lower a node");

endmodule

>>> sv/fpm_ctrl.sv
// Controller: clearing pass, walk sequencing and output register handshake.
`timescale 1ns / 1ps

module fpm_ctrl import fpm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  fpm_sts_t sts,
  output fpm_ctl_t ctl
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_HOLD
  } state_t;

  state_t state;
  state_t state_next;
  logic   done;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  // Last node's data is back once no further node is left to issue.
  assign done     = (state == S_WALK) && !sts.walk_more;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl.load       = (state == S_IDLE) && in_valid;
    ctl.step       = (state == S_WALK);
    ctl.clear_step = (state == S_CLEAR);
    ctl.load_out   = sts.is_query && out_free && (done || (state == S_HOLD));
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_WALK;
      end
      S_WALK: begin
        if (done) begin
          state_next = (sts.is_query && !out_free) ? S_HOLD : S_IDLE;
        end
      end
      S_HOLD: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The result register is never overwritten while it still holds an untaken result.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |-> out_free)
    else $error("result register overwritten before transfer");

  // A finished query either presents its result or holds it.
  a_query_result: assert property (@(posedge clk) disable iff (rst)
    (done && sts.is_query) |=> (out_valid || (state == S_HOLD)))
    else $error("query finished without a result");

  // Raises never load the result register.
  a_raise_silent: assert property (@(posedge clk) disable iff (rst)
    (done && !sts.is_query) |-> !ctl.load_out)
    else $error("raise produced a result");

  // Node reads are only outstanding while a walk is running.
  a_pend_in_walk: assert property (@(posedge clk) disable iff (rst)
    (state != S_WALK) |-> !sts.rd_pend)
    else $error("node read outstanding outside a walk");

endmodule

>>> sv/fenwick_prefix_max_table.sv
// Top level of the Fenwick prefix-max table: controller plus datapath.
//
//   channel  | handshake           | payload
//   ---------+---------------------+---------------------------
//   input    | in_valid / in_ready | cmd, index, value
//   result   | out_valid/out_ready | prefix_max (queries only)
//   config   | cfg_we              | cfg_data (used_size)
//
// An item walks the nodes on its tree path (at most log2(depth) + 1, so 11 at the
// default depth), making one node memory access per cycle.
// After reset a clearing pass zeroes every address of the node memory;
// in_ready stays low meanwhile, configuration writes are still taken.
// A query result waits in the output register; the next item is accepted
// while it waits, and only a second query finishing stalls until it transfers.
`timescale 1ns / 1ps

module fenwick_prefix_max_table import fpm_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  localparam int IW = $clog2(TABLE_DEPTH),
  localparam int SW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [SW-1:0]          cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   cmd,
  input  logic [IW-1:0]          index,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] prefix_max
);

  fpm_ctl_t ctl;
  fpm_sts_t sts;

  fpm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  fpm_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .index      (index),
    .value      (value),
    .ctl        (ctl),
    .sts        (sts),
    .prefix_max (prefix_max)
  );

endmodule

>>> dv/fenwick_prefix_max_table_tb.sv
// Testbench for the Fenwick prefix-max table: directed and random raise/query traffic.
`timescale 1ns / 1ps

module fenwick_prefix_max_table_tb import fpm_pkg::*; ();

  localparam int DEPTH       = DEF_TABLE_DEPTH;
  localparam int SETTLE      = 24;
  localparam int STALL_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = CMD_RAISE;
  logic [9:0]  index = '0;
  logic [31:0] value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] prefix_max;

  // Predicted table state
  bit [31:0]   node_max [1:DEPTH];
  logic [10:0] size_setting = 11'(USED_SIZE_RESET);
  logic [31:0] pending_max [$];

  bit          no_gaps = 1'b0;
  int unsigned mismatches = 0;
  int unsigned n_raise = 0;
  int unsigned n_query = 0;
  int unsigned n_checked = 0;
  int unsigned n_sizes = 0;
  int unsigned idle_cycles = 0;

  fenwick_prefix_max_table dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .index     (index),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .prefix_max(prefix_max)
  );

  always #10 clk = ~clk;

  function automatic int unsigned table_span();
    int unsigned n;
    n = size_setting;
    if (n == 0) n = 1;
    if (n > DEPTH) n = DEPTH;
    return n;
  endfunction

  function automatic void table_raise(input int unsigned pos, input logic [31:0] v);
    int unsigned n;
    int unsigned node;
    n = table_span();
    if (pos >= n) pos = n - 1;
    for (node = pos + 1; node <= n; node += node & (~node + 1))
      if (node_max[node] < v) node_max[node] = v;
  endfunction

  function automatic logic [31:0] table_query(input int unsigned pos);
    int unsigned n;
    int unsigned node;
    logic [31:0] best;
    n = table_span();
    best = '0;
    if (pos >= n) pos = n - 1;
    for (node = pos + 1; node > 0; node -= node & (~node + 1))
      if (node_max[node] > best) best = node_max[node];
    return best;
  endfunction

  task automatic send_item(input logic c, input logic [9:0] idx, input logic [31:0] v);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    cmd      <= c;
    index    <= idx;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    if (c == CMD_QUERY) begin
      pending_max.insert(pending_max.size(), table_query(idx));
      n_query++;
    end else begin
      table_raise(idx, v);
      n_raise++;
    end
  endtask

  // Drain all results and let any raise still walking the tree finish first.
  task automatic write_used_size(input logic [10:0] n);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_max.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= n;
    @(negedge clk);
    cfg_we <= 1'b0;
    size_setting = n;
    n_sizes++;
  endtask

  task automatic test_empty_table();
    send_item(CMD_QUERY, 10'd0, 32'hFFFF_FFFF);
    send_item(CMD_QUERY, 10'd1023, 32'h0);
  endtask

  task automatic test_value_extremes();
    send_item(CMD_RAISE, 10'd0, 32'h0);
    send_item(CMD_QUERY, 10'd0, 32'h0);
    send_item(CMD_RAISE, 10'd1023, 32'hFFFF_FFFF);
    send_item(CMD_QUERY, 10'd1022, 32'h0);
    send_item(CMD_QUERY, 10'd1023, 32'h0);
    send_item(CMD_RAISE, 10'd511, 32'h1);
    send_item(CMD_QUERY, 10'd600, 32'h0);
  endtask

  // Size zero acts as one, oversize acts as the full depth, indices clamp.
  task automatic test_size_clamp();
    write_used_size(11'd0);
    send_item(CMD_RAISE, 10'd700, 32'h55);
    send_item(CMD_QUERY, 10'd0, 32'h0);
    write_used_size(11'd2047);
    send_item(CMD_QUERY, 10'd1023, 32'h0);
    write_used_size(11'd10);
    send_item(CMD_QUERY, 10'd1023, 32'h0);
    send_item(CMD_RAISE, 10'd1023, 32'hAAAA_AAAA);
    send_item(CMD_QUERY, 10'd9, 32'h0);
  endtask

  // Tree contents survive a size change; walks just stop at the new size.
  task automatic test_resize_keeps_tree();
    write_used_size(11'd3);
    send_item(CMD_RAISE, 10'd2, 32'h100);
    write_used_size(11'd8);
    send_item(CMD_QUERY, 10'd7, 32'h0);
    send_item(CMD_QUERY, 10'd2, 32'h0);
  endtask

  task automatic test_random(input logic [10:0] size, input int unsigned count);
    logic        c;
    logic [9:0]  idx;
    logic [31:0] v;
    int unsigned n;
    write_used_size(size);
    n = table_span();
    for (int k = 0; k < count; k++) begin
      if (k % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      c = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 6) == 0) idx = 10'($urandom);
      else idx = 10'($urandom_range(0, n - 1));
      case ($urandom_range(0, 3))
        0: v = $urandom_range(0, 255);
        1: v = 32'hFFFF_FFFF - $urandom_range(0, 3);
        default: v = $urandom >> $urandom_range(0, 31);
      endcase
      send_item(c, idx, v);
    end
    no_gaps = 1'b0;
  endtask

  // Result side: random stall before each transfer
  initial begin
    int unsigned stall;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 11);
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && out_valid && out_ready) begin
      if (pending_max.size() == 0) begin
        mismatches++;
        $error("prefix_max: no result expected, got %h", prefix_max);
      end else begin
        want = pending_max.pop_front();
        n_checked++;
        if (prefix_max !== want) begin
          mismatches++;
          $error("prefix_max: expected %h, actual %h", want, prefix_max);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_value_extremes();
    test_size_clamp();
    test_resize_keeps_tree();
    test_random(11'd1024, 300);
    test_random(11'd37, 150);
    test_random(11'd0, 50);
    test_random(11'd2047, 150);
    test_random(11'd512, 200);
    test_random(11'd5, 50);
    test_random(11'd1, 50);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_max.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (pending_max.size() != 0) begin
      mismatches++;
      $error("prefix_max: %0d results never arrived", pending_max.size());
    end
    $display("covered %0d raises and %0d queries over %0d size settings",
             n_raise, n_query, n_sizes);
    $display("%0d prefix maxima compared, %0d mismatches", n_checked, mismatches);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
